// ===== design/qrd_pkg.sv =====
// qrd_pkg: shared types and constants of the quadtree region decomposer
// used by the top, scan and walk modules and by the checker; no dependencies
`timescale 1ns / 1ps

package qrd_pkg;

  localparam int unsigned MaxDimDef    = 64;
  localparam int unsigned MaxLevelsDef = 7;
  localparam int unsigned DimReset     = 64;

  localparam logic [1:0] ColorMixed = 2'd2;
  localparam logic [1:0] NoKids     = 2'd3;

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqFetch = 1'b1;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  typedef enum logic [1:0] {
    Q_NW = 2'd0,
    Q_SW = 2'd1,
    Q_SE = 2'd2,
    Q_NE = 2'd3
  } quad_e;

  typedef struct packed {
    logic       done;
    logic [1:0] color;
  } scan_stat_t;

endpackage

// ===== design/quadtree_region_decomposer_top.sv =====
// Quadtree region decomposer. A load is taken while idle and yields no result.
// A fetch scans one pixel per cycle; with the result register free its node is valid
// and the input ready again once any levels are popped or a sibling is stepped to, the
// node is scanned and, when it is mixed, each of its four children is scanned in turn.
// Reset: rows and columns 64, load pointer zero, next fetch yields the root;
// the pixel store is not cleared and holds nothing defined until loaded.
`timescale 1ns / 1ps

module quadtree_region_decomposer_top import qrd_pkg::*; #(
  parameter int unsigned MAX_DIM    = MaxDimDef,
  parameter int unsigned MAX_LEVELS = MaxLevelsDef,
  localparam int unsigned DW   = $clog2(MAX_DIM + 1),
  localparam int unsigned OW   = $clog2(MAX_DIM),
  localparam int unsigned RAWW = 12 + 2 * DW + 2 * OW,
  localparam int unsigned TDW  = ((RAWW + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // pixel
  input  logic           s_axis_tuser,   // req_type
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // node_color, region_rows, region_cols, min_value, max_value, row_start,
  // col_start, nw_color, sw_color, se_color, ne_color
  output logic [TDW-1:0] m_axis_tdata,
  output logic           m_axis_tlast,   // last_node
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [DW-1:0]  cfg_data_i
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RstDim = (MAX_DIM < DimReset) ? MAX_DIM : DimReset;

  logic [DW-1:0]   rows_q, cols_q, rows_c, cols_c;
  logic [AW-1:0]   lp_q;
  logic [2*DW-1:0] total, lp_inc;
  logic            cfg_wr, load;

  logic            scan_start, rd_data;
  logic [OW-1:0]   scan_r0, scan_c0;
  logic [DW-1:0]   scan_nr, scan_nc;
  logic [AW-1:0]   rd_addr;
  scan_stat_t      scan_stat;

  logic [1:0]      node_color;
  logic [DW-1:0]   region_rows, region_cols;
  logic            min_value, max_value;
  logic [OW-1:0]   row_start, col_start;
  logic [3:0][1:0] kid_color;

  assign cfg_ready_o = s_axis_tready;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign load        = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ReqLoad);

  assign rows_c = (rows_q == '0) ? DW'(1) : (rows_q > DW'(MAX_DIM)) ? DW'(MAX_DIM) : rows_q;
  assign cols_c = (cols_q == '0) ? DW'(1) : (cols_q > DW'(MAX_DIM)) ? DW'(MAX_DIM) : cols_q;
  assign total  = (2*DW)'(rows_c) * (2*DW)'(cols_c);
  assign lp_inc = (2*DW)'(lp_q) + (2*DW)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DW'(RstDim);
      cols_q <= DW'(RstDim);
      lp_q   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index_i)
          CfgRows: rows_q <= cfg_data_i;
          CfgCols: cols_q <= cfg_data_i;
          default: ;
        endcase
        lp_q <= '0;
      end else if (load) begin
        lp_q <= (lp_inc >= total) ? '0 : AW'(lp_inc);
      end
    end
  end

  qrd_pixmem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_pixmem (
    .clk_i  (clk_i),
    .we_i   (load),
    .waddr_i(lp_q),
    .wdata_i(s_axis_tdata[0]),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  qrd_scan #(
    .DW(DW),
    .OW(OW),
    .AW(AW)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .r0_i     (scan_r0),
    .c0_i     (scan_c0),
    .nr_i     (scan_nr),
    .nc_i     (scan_nc),
    .cols_i   (cols_c),
    .rd_data_i(rd_data),
    .rd_addr_o(rd_addr),
    .stat_o   (scan_stat)
  );

  qrd_walk #(
    .MAX_LEVELS(MAX_LEVELS),
    .DW        (DW),
    .OW        (OW)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_type_i    (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .restart_i    (cfg_wr),
    .rows_i       (rows_c),
    .cols_i       (cols_c),
    .scan_start_o (scan_start),
    .scan_r0_o    (scan_r0),
    .scan_c0_o    (scan_c0),
    .scan_nr_o    (scan_nr),
    .scan_nc_o    (scan_nc),
    .scan_stat_i  (scan_stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .node_color_o (node_color),
    .region_rows_o(region_rows),
    .region_cols_o(region_cols),
    .min_value_o  (min_value),
    .max_value_o  (max_value),
    .row_start_o  (row_start),
    .col_start_o  (col_start),
    .kid_color_o  (kid_color),
    .last_node_o  (m_axis_tlast)
  );

  assign m_axis_tdata = TDW'({kid_color[Q_NE], kid_color[Q_SE], kid_color[Q_SW],
                              kid_color[Q_NW], col_start, row_start, max_value,
                              min_value, region_cols, region_rows, node_color});

endmodule

// ===== design/qrd_pixmem.sv =====
// qrd_pixmem: single-bit pixel store, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module qrd_pixmem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/qrd_scan.sv =====
// qrd_scan: shared region scan unit, walks one pixel per cycle through the store
// and reports uniform colour or mixed; depends on qrd_pkg
`timescale 1ns / 1ps

module qrd_scan import qrd_pkg::*; #(
  parameter int unsigned DW = 7,
  parameter int unsigned OW = 6,
  parameter int unsigned AW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [OW-1:0] r0_i,
  input  logic [OW-1:0] c0_i,
  input  logic [DW-1:0] nr_i,
  input  logic [DW-1:0] nc_i,
  input  logic [DW-1:0] cols_i,
  input  logic          rd_data_i,
  output logic [AW-1:0] rd_addr_o,
  output scan_stat_t    stat_o
);

  typedef enum logic [5:0] {
    SC_IDLE  = 6'b000001,
    SC_MUL   = 6'b000010,
    SC_FIRST = 6'b000100,
    SC_SCAN  = 6'b001000,
    SC_DRAIN = 6'b010000,
    SC_DONE  = 6'b100000
  } scan_state_e;

  scan_state_e state_q, state_d;

  logic [OW-1:0]    r0_q, c0_q;
  logic [DW-1:0]    nr_q, nc_q;
  logic [DW-1:0]    i_q, j_q;
  logic [AW-1:0]    addr_q, row_q;
  logic             pend_q, ref_ok_q, ref_q, mixed_q;
  logic [OW+DW-1:0] prod;
  logic [AW-1:0]    base, cols_aw;
  logic             issue, last_col, last_row, empty;

  assign prod     = (OW+DW)'(r0_q) * (OW+DW)'(cols_i);
  assign base     = AW'(prod) + AW'(c0_q);
  assign cols_aw  = AW'(cols_i);
  assign last_col = (j_q == nc_q - DW'(1));
  assign last_row = (i_q == nr_q - DW'(1));
  assign empty    = (nr_q == '0) || (nc_q == '0);
  assign issue    = (state_q == SC_FIRST) || (state_q == SC_SCAN);

  assign rd_addr_o    = addr_q;
  assign stat_o.done  = (state_q == SC_DONE);
  assign stat_o.color = mixed_q ? ColorMixed : {1'b0, ref_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SC_IDLE:  if (start_i) state_d = SC_MUL;
      SC_MUL:   state_d = SC_FIRST;
      SC_FIRST: state_d = empty ? SC_DRAIN : SC_SCAN;
      SC_SCAN:  if (last_col && last_row) state_d = SC_DRAIN;
      SC_DRAIN: state_d = SC_DONE;
      SC_DONE:  state_d = SC_IDLE;
      default:  state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SC_IDLE && start_i) begin
      r0_q     <= r0_i;
      c0_q     <= c0_i;
      nr_q     <= nr_i;
      nc_q     <= nc_i;
      ref_ok_q <= 1'b0;
      mixed_q  <= 1'b0;
    end
    if (state_q == SC_MUL) begin
      addr_q <= base;
      row_q  <= base;
      i_q    <= '0;
      j_q    <= '0;
    end
    if (state_q == SC_SCAN) begin
      if (last_col) begin
        j_q    <= '0;
        i_q    <= i_q + DW'(1);
        row_q  <= row_q + cols_aw;
        addr_q <= row_q + cols_aw;
      end else begin
        j_q    <= j_q + DW'(1);
        addr_q <= addr_q + AW'(1);
      end
    end
    // first returned pixel is the reference, the rest are compared against it
    if (pend_q) begin
      if (!ref_ok_q) begin
        ref_q    <= rd_data_i;
        ref_ok_q <= 1'b1;
      end else if (rd_data_i != ref_q) begin
        mixed_q <= 1'b1;
      end
    end
  end

endmodule

// ===== design/qrd_walk.sv =====
// qrd_walk: preorder walk sequencer, region stack and result register
// drives the shared scan unit; depends on qrd_pkg
`timescale 1ns / 1ps

module qrd_walk import qrd_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 7,
  parameter int unsigned DW         = 7,
  parameter int unsigned OW         = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_type_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  input  logic [DW-1:0]       rows_i,
  input  logic [DW-1:0]       cols_i,
  output logic                scan_start_o,
  output logic [OW-1:0]       scan_r0_o,
  output logic [OW-1:0]       scan_c0_o,
  output logic [DW-1:0]       scan_nr_o,
  output logic [DW-1:0]       scan_nc_o,
  input  scan_stat_t          scan_stat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          node_color_o,
  output logic [DW-1:0]       region_rows_o,
  output logic [DW-1:0]       region_cols_o,
  output logic                min_value_o,
  output logic                max_value_o,
  output logic [OW-1:0]       row_start_o,
  output logic [OW-1:0]       col_start_o,
  output logic [3:0][1:0]     kid_color_o,
  output logic                last_node_o
);

  localparam int unsigned LW = $clog2(MAX_LEVELS);
  localparam logic [LW-1:0] LastLvl = LW'(MAX_LEVELS - 1);

  typedef enum logic [6:0] {
    W_IDLE  = 7'b0000001,
    W_POP   = 7'b0000010,
    W_EVAL  = 7'b0000100,
    W_NWAIT = 7'b0001000,
    W_KID   = 7'b0010000,
    W_KWAIT = 7'b0100000,
    W_OUT   = 7'b1000000
  } walk_state_e;

  walk_state_e state_q, state_d;

  logic             active_q, prev_kids_q, out_valid_q;
  logic [LW-1:0]    level_q, nxt_lvl;
  quad_e            kid_q;
  quad_e            qd_q [MAX_LEVELS];
  logic [OW-1:0]    rr_q [MAX_LEVELS];
  logic [OW-1:0]    rc_q [MAX_LEVELS];
  logic [DW-1:0]    rn_q [MAX_LEVELS];
  logic [DW-1:0]    cn_q [MAX_LEVELS];
  logic [1:0]       col_q;
  logic [3:0][1:0]  kcol_q;

  logic [OW-1:0]    cur_r, cur_c, kr, kc, sr, sc;
  logic [DW-1:0]    cur_n, cur_nc, half_n, half_nc;
  quad_e            cur_q, nq;
  logic             fetch, load, kids_now, pop_up, out_fire, all_ne, last;

  assign in_ready_o  = (state_q == W_IDLE);
  assign out_valid_o = out_valid_q;
  assign fetch = in_valid_i && in_ready_o && (in_type_i == ReqFetch);
  assign load  = in_valid_i && in_ready_o && (in_type_i == ReqLoad);

  assign nxt_lvl = level_q + LW'(1);
  assign cur_r   = rr_q[level_q];
  assign cur_c   = rc_q[level_q];
  assign cur_n   = rn_q[level_q];
  assign cur_nc  = cn_q[level_q];
  assign cur_q   = qd_q[level_q];
  assign half_n  = cur_n >> 1;
  assign half_nc = cur_nc >> 1;

  // child region of the current node for the quadrant being scanned
  assign kr = cur_r + (((kid_q == Q_SW) || (kid_q == Q_SE)) ? OW'(half_n) : '0);
  assign kc = cur_c + (((kid_q == Q_SE) || (kid_q == Q_NE)) ? OW'(half_nc) : '0);

  // next sibling, reached from the current node by its own size
  assign nq = quad_e'(cur_q + 2'd1);
  assign sr = (nq == Q_SW) ? cur_r + OW'(cur_n) :
              (nq == Q_NE) ? cur_r - OW'(cur_n) : cur_r;
  assign sc = (nq == Q_SE) ? cur_c + OW'(cur_nc) : cur_c;

  assign pop_up   = (level_q != '0) && (cur_q == Q_NE);
  assign kids_now = (scan_stat_i.color == ColorMixed) && (level_q != LastLvl);
  assign out_fire = (state_q == W_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    all_ne = 1'b1;
    for (int unsigned k = 1; k < MAX_LEVELS; k++) begin
      if ((LW'(k) <= level_q) && (qd_q[k] != Q_NE)) all_ne = 1'b0;
    end
  end

  assign last = !prev_kids_q && all_ne;

  assign scan_start_o = (state_q == W_EVAL) || (state_q == W_KID);
  assign scan_r0_o    = (state_q == W_KID) ? kr : cur_r;
  assign scan_c0_o    = (state_q == W_KID) ? kc : cur_c;
  assign scan_nr_o    = (state_q == W_KID) ? half_n : cur_n;
  assign scan_nc_o    = (state_q == W_KID) ? half_nc : cur_nc;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_IDLE:  if (fetch) state_d = (!active_q || prev_kids_q) ? W_EVAL : W_POP;
      W_POP:   if (!pop_up) state_d = W_EVAL;
      W_EVAL:  state_d = W_NWAIT;
      W_NWAIT: if (scan_stat_i.done) state_d = kids_now ? W_KID : W_OUT;
      W_KID:   state_d = W_KWAIT;
      W_KWAIT: if (scan_stat_i.done) state_d = (kid_q == Q_NE) ? W_OUT : W_KID;
      W_OUT:   if (out_fire) state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= W_IDLE;
      active_q    <= 1'b0;
      prev_kids_q <= 1'b0;
      level_q     <= '0;
      kid_q       <= Q_NW;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        W_IDLE: begin
          if (fetch) begin
            if (!active_q) begin
              active_q <= 1'b1;
              level_q  <= '0;
            end else if (prev_kids_q) begin
              level_q <= nxt_lvl;
            end
          end else if (load) begin
            active_q <= 1'b0;
            level_q  <= '0;
          end
        end
        W_POP: if (pop_up) level_q <= level_q - LW'(1);
        W_NWAIT: begin
          if (scan_stat_i.done) begin
            prev_kids_q <= kids_now;
            kid_q       <= Q_NW;
          end
        end
        W_KWAIT: if (scan_stat_i.done) kid_q <= quad_e'(kid_q + 2'd1);
        W_OUT: begin
          if (out_fire) begin
            out_valid_q <= 1'b1;
            if (last) begin
              active_q <= 1'b0;
              level_q  <= '0;
            end
          end
        end
        default: ;
      endcase
      if (restart_i) begin
        active_q <= 1'b0;
        level_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == W_IDLE) && fetch) begin
      if (!active_q) begin
        rr_q[0] <= '0;
        rc_q[0] <= '0;
        rn_q[0] <= rows_i;
        cn_q[0] <= cols_i;
      end else if (prev_kids_q) begin
        qd_q[nxt_lvl] <= Q_NW;
        rr_q[nxt_lvl] <= cur_r;
        rc_q[nxt_lvl] <= cur_c;
        rn_q[nxt_lvl] <= half_n;
        cn_q[nxt_lvl] <= half_nc;
      end
    end
    if ((state_q == W_POP) && !pop_up && (level_q != '0)) begin
      qd_q[level_q] <= nq;
      rr_q[level_q] <= sr;
      rc_q[level_q] <= sc;
    end
    if ((state_q == W_NWAIT) && scan_stat_i.done) col_q <= scan_stat_i.color;
    if ((state_q == W_KWAIT) && scan_stat_i.done) kcol_q[kid_q] <= scan_stat_i.color;
    if (out_fire) begin
      node_color_o  <= col_q;
      region_rows_o <= cur_n;
      region_cols_o <= cur_nc;
      min_value_o   <= (col_q == ColorMixed) ? 1'b0 : col_q[0];
      max_value_o   <= (col_q == ColorMixed) ? 1'b1 : col_q[0];
      row_start_o   <= cur_r;
      col_start_o   <= cur_c;
      kid_color_o   <= prev_kids_q ? kcol_q : {4{NoKids}};
      last_node_o   <= last;
    end
  end

endmodule

// ===== design/qrd_checker.sv =====
// qrd_checker: port-level assertions for the quadtree region decomposer
// bound to quadtree_region_decomposer_top; depends on qrd_pkg
`timescale 1ns / 1ps

module qrd_checker import qrd_pkg::*; #(
  parameter int unsigned MAX_DIM = MaxDimDef,
  localparam int unsigned DW   = $clog2(MAX_DIM + 1),
  localparam int unsigned OW   = $clog2(MAX_DIM),
  localparam int unsigned RAWW = 12 + 2 * DW + 2 * OW,
  localparam int unsigned TDW  = ((RAWW + 7) / 8) * 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic           s_axis_tuser,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata,
  input logic           m_axis_tlast,
  input logic           cfg_ready_o
);

  localparam int unsigned MinB = 2 + 2 * DW;
  localparam int unsigned MaxB = MinB + 1;
  localparam int unsigned KidB = MaxB + 1 + 2 * OW;

  logic [1:0] ncol;
  logic       nmin, nmax;
  logic [7:0] kids;

  assign ncol = m_axis_tdata[1:0];
  assign nmin = m_axis_tdata[MinB];
  assign nmax = m_axis_tdata[MaxB];
  assign kids = m_axis_tdata[KidB +: 8];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ReqFetch) |=> !s_axis_tready)
    else $error("fetch did not occupy the block");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ReqLoad) |=> s_axis_tready)
    else $error("load stalled the input");

  a_uniform_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (ncol != ColorMixed) |->
      (ncol != NoKids) && (nmin == ncol[0]) && (nmax == ncol[0]) && (kids == 8'hFF))
    else $error("uniform node with bad bounds or children");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == s_axis_tready)
    else $error("config ready out of step with input ready");

endmodule

bind quadtree_region_decomposer_top qrd_checker #(.MAX_DIM(MAX_DIM)) u_qrd_checker (.*);
